// ===== design/kcef_pkg.sv =====
package kcef_pkg;

    typedef logic [3:0] t_state;
    typedef logic [2:0] t_event;

    localparam int TickW = 32;
    localparam int CfgW  = 16;
    localparam int AddrW = 3;

    localparam t_state ST_IDLE       = 4'd0;
    localparam t_state ST_PRESS_DB   = 4'd1;
    localparam t_state ST_PRESS      = 4'd2;
    localparam t_state ST_REL_DB     = 4'd3;
    localparam t_state ST_RELEASE    = 4'd4;
    localparam t_state ST_CLICK_WAIT = 4'd5;
    localparam t_state ST_DPRESS_DB  = 4'd6;
    localparam t_state ST_DREL_DB    = 4'd7;
    localparam t_state ST_CLICK      = 4'd8;
    localparam t_state ST_DOUBLE     = 4'd9;
    localparam t_state ST_LONG       = 4'd10;
    localparam t_state ST_LONG_REP   = 4'd11;
    localparam t_state ST_LOCK       = 4'd12;

    localparam t_event EV_NONE   = 3'd0;
    localparam t_event EV_CLICK  = 3'd1;
    localparam t_event EV_DOUBLE = 3'd2;
    localparam t_event EV_LONG   = 3'd3;
    localparam t_event EV_REPEAT = 3'd4;

    localparam logic [AddrW-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [AddrW-1:0] REG_LOCK     = 3'd1;
    localparam logic [AddrW-1:0] REG_LONG     = 3'd2;
    localparam logic [AddrW-1:0] REG_REPEAT   = 3'd3;
    localparam logic [AddrW-1:0] REG_DWINDOW  = 3'd4;

    localparam logic [CfgW-1:0] RST_DEBOUNCE = 16'd20;
    localparam logic [CfgW-1:0] RST_LOCK     = 16'd200;
    localparam logic [CfgW-1:0] RST_LONG     = 16'd1000;
    localparam logic [CfgW-1:0] RST_REPEAT   = 16'd200;
    localparam logic [CfgW-1:0] RST_DWINDOW  = 16'd300;

endpackage

// ===== design/key_click_event_fsm_top.sv =====
// Output: each result is registered, reaching the master side in the next cycle.
// Throughput: one poll per cycle; the next-state logic works combinationally from the
// state register, and a poll transfers whenever the output register is empty or
// its result leaves in the same cycle, so a stalled master side holds the slave side.
// Reset: synchronous, active low; state goes to idle, reference tick to zero,
// registers to their defaults, and the output register empties.
module key_click_event_fsm_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [kcef_pkg::AddrW-1:0] i_cfg_addr,
    input  logic [kcef_pkg::CfgW-1:0]  i_cfg_wdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [31:0] now_tick, [32] pressed, [39:33] zero
    input  logic [39:0]                i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // [2:0] event_res, [6:3] fsm_state, [7] zero
    output logic [7:0]                 o_m_axis_tdata
);

    logic [kcef_pkg::CfgW-1:0]  r_debounce;
    logic [kcef_pkg::CfgW-1:0]  r_lock;
    logic [kcef_pkg::CfgW-1:0]  r_long;
    logic [kcef_pkg::CfgW-1:0]  r_repeat;
    logic [kcef_pkg::CfgW-1:0]  r_dwindow;

    kcef_pkg::t_state           r_state, n_state;
    kcef_pkg::t_state           r_ret_state, n_ret_state;
    logic [kcef_pkg::TickW-1:0] r_ref_tick, n_ref_tick;
    kcef_pkg::t_event           n_event;

    logic                       r_out_valid;
    logic [7:0]                 r_out_data;

    logic [kcef_pkg::TickW-1:0] now_tick;
    logic                       pressed;
    logic [kcef_pkg::TickW-1:0] dt;
    logic [kcef_pkg::TickW-1:0] debounce_x, lock_x, long_x, repeat_x, dwindow_x;
    logic                       in_xfer;

    assign now_tick   = i_s_axis_tdata[31:0];
    assign pressed    = i_s_axis_tdata[32];
    assign dt         = now_tick - r_ref_tick;
    assign debounce_x = {16'd0, r_debounce};
    assign lock_x     = {16'd0, r_lock};
    assign long_x     = {16'd0, r_long};
    assign repeat_x   = {16'd0, r_repeat};
    assign dwindow_x  = {16'd0, r_dwindow};

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= kcef_pkg::RST_DEBOUNCE;
            r_lock     <= kcef_pkg::RST_LOCK;
            r_long     <= kcef_pkg::RST_LONG;
            r_repeat   <= kcef_pkg::RST_REPEAT;
            r_dwindow  <= kcef_pkg::RST_DWINDOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                kcef_pkg::REG_DEBOUNCE: r_debounce <= i_cfg_wdata;
                kcef_pkg::REG_LOCK:     r_lock     <= i_cfg_wdata;
                kcef_pkg::REG_LONG:     r_long     <= i_cfg_wdata;
                kcef_pkg::REG_REPEAT:   r_repeat   <= i_cfg_wdata;
                kcef_pkg::REG_DWINDOW:  r_dwindow  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret_state = r_ret_state;
        n_ref_tick  = r_ref_tick;
        n_event     = kcef_pkg::EV_NONE;
        unique case (r_state)
            kcef_pkg::ST_IDLE: begin
                if (pressed) begin
                    n_ref_tick = now_tick;
                    n_state    = kcef_pkg::ST_PRESS_DB;
                end
            end
            kcef_pkg::ST_PRESS_DB: begin
                if (!pressed) begin
                    n_state = kcef_pkg::ST_IDLE;
                end else if (dt > debounce_x) begin
                    n_state = kcef_pkg::ST_PRESS;
                end
            end
            kcef_pkg::ST_PRESS: begin
                if (!pressed) begin
                    n_ref_tick  = now_tick;
                    n_ret_state = kcef_pkg::ST_PRESS;
                    n_state     = kcef_pkg::ST_REL_DB;
                end else if (dt >= long_x) begin
                    n_state = kcef_pkg::ST_LONG;
                end
            end
            kcef_pkg::ST_REL_DB: begin
                if (pressed) begin
                    n_state = r_ret_state;
                end else if (dt > debounce_x) begin
                    n_state = (r_ret_state == kcef_pkg::ST_PRESS) ?
                              kcef_pkg::ST_RELEASE : kcef_pkg::ST_IDLE;
                end
            end
            kcef_pkg::ST_RELEASE: begin
                if (r_dwindow != '0) begin
                    n_ref_tick = now_tick;
                    n_state    = kcef_pkg::ST_CLICK_WAIT;
                end else begin
                    n_state = kcef_pkg::ST_CLICK;
                end
            end
            kcef_pkg::ST_CLICK_WAIT: begin
                if (pressed) begin
                    n_ref_tick = now_tick;
                    n_state    = kcef_pkg::ST_DPRESS_DB;
                end else if (dt >= dwindow_x) begin
                    n_state = kcef_pkg::ST_CLICK;
                end
            end
            kcef_pkg::ST_DPRESS_DB: begin
                if (pressed) begin
                    if (dt > debounce_x) begin
                        n_ref_tick = now_tick;
                        n_state    = kcef_pkg::ST_DREL_DB;
                    end
                end else begin
                    n_ref_tick = now_tick;
                    n_state    = kcef_pkg::ST_CLICK_WAIT;
                end
            end
            kcef_pkg::ST_DREL_DB: begin
                if (dt <= dwindow_x) begin
                    if (!pressed && dt > debounce_x) begin
                        n_state = kcef_pkg::ST_DOUBLE;
                    end
                end else if (!pressed) begin
                    n_state = kcef_pkg::ST_IDLE;
                end
            end
            kcef_pkg::ST_CLICK: begin
                n_event = kcef_pkg::EV_CLICK;
                n_state = kcef_pkg::ST_IDLE;
            end
            kcef_pkg::ST_DOUBLE: begin
                n_event    = kcef_pkg::EV_DOUBLE;
                n_ref_tick = now_tick;
                n_state    = kcef_pkg::ST_LOCK;
            end
            kcef_pkg::ST_LONG: begin
                n_event    = kcef_pkg::EV_LONG;
                n_ref_tick = now_tick;
                n_state    = kcef_pkg::ST_LONG_REP;
            end
            kcef_pkg::ST_LONG_REP: begin
                if (!pressed) begin
                    n_ref_tick  = now_tick;
                    n_ret_state = kcef_pkg::ST_LONG_REP;
                    n_state     = kcef_pkg::ST_REL_DB;
                end else if (dt >= repeat_x) begin
                    n_ref_tick = now_tick;
                    n_event    = kcef_pkg::EV_REPEAT;
                end
            end
            kcef_pkg::ST_LOCK: begin
                if (dt > lock_x) begin
                    n_state = kcef_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kcef_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kcef_pkg::ST_IDLE;
            r_ret_state <= kcef_pkg::ST_IDLE;
            r_ref_tick  <= '0;
        end else if (in_xfer) begin
            r_state     <= n_state;
            r_ret_state <= n_ret_state;
            r_ref_tick  <= n_ref_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= {1'b0, n_state, n_event};
        end
    end

`ifndef SYNTH
    a_state_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[6:3] == r_state))
        else $error("reported state differs from state register");

    a_click_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_state == kcef_pkg::ST_CLICK) |=>
        (r_out_valid && r_out_data[2:0] == kcef_pkg::EV_CLICK
         && r_state == kcef_pkg::ST_IDLE))
        else $error("click state did not report a click");

    a_double_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[2:0] == kcef_pkg::EV_DOUBLE) |->
        (r_state == kcef_pkg::ST_LOCK))
        else $error("double click not followed by lock");

    a_press_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_state == kcef_pkg::ST_IDLE && pressed) |=>
        (r_ref_tick == $past(now_tick) && r_state == kcef_pkg::ST_PRESS_DB))
        else $error("press from idle did not capture reference tick");
`endif

endmodule
